### sv/assert_macros.svh
// assertion helpers for the checker file msr_check.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("check failed");

// next-cycle implication, held off during reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("check failed");

`endif

### sv/msr_pkg.sv
package msr_pkg;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_NONRES = 2'd1;
	localparam logic [1:0] ST_LIMIT  = 2'd2;

	// widest candidate tried in the non-residue search: 2 + 65534
	localparam int ZW = 17;

	typedef logic [1:0] status_t;

endpackage

### sv/modular_square_root_top.sv
// Modular square root by Tonelli-Shanks: takes value and prime and returns a root of value
// modulo prime with a status (ok, non-residue, non-residue search limit reached); for a
// modulus that is not prime the answer is unspecified. All modular products run through one
// bit-serial modular multiplier; a modular power costs up to about 2*WIDTH products. An item
// with a modulus below three needs no product; otherwise one item takes a few powers for the
// residue check and the 3 mod 4 case, and up to search_limit further powers plus up to
// WIDTH*WIDTH squarings for the full Tonelli-Shanks loop. in_ready is high only while no
// item is being worked on; a finished word waits in the output register, so the next item
// may be taken before it is collected.
module modular_square_root_top #(
	parameter int WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] value,
	input  logic [31:0] prime,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] root,
	output logic [1:0]  status,
	input  logic        cfg_we,
	input  logic [15:0] cfg_data
);

	localparam int MB = (WIDTH > msr_pkg::ZW) ? WIDTH : msr_pkg::ZW;

	logic [15:0]      limit_q;
	logic             out_valid_q;
	logic [31:0]      root_q;
	msr_pkg::status_t status_q;

	logic             idle, fin_valid, fin_take;
	logic [WIDTH-1:0] res_root;
	msr_pkg::status_t res_status;
	logic             mul_start, mul_done;
	logic [WIDTH-1:0] mul_a, mul_m, mul_prod;
	logic [MB-1:0]    mul_b;

	assign in_ready = idle;
	assign fin_take = !out_valid_q || out_ready;

	msr_seq #(.W(WIDTH), .MB(MB)) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (in_valid && idle),
		.v          (WIDTH'(value)),
		.p          (WIDTH'(prime)),
		.limit      (limit_q),
		.idle       (idle),
		.fin_valid  (fin_valid),
		.fin_take   (fin_take),
		.res_root   (res_root),
		.res_status (res_status),
		.mul_start  (mul_start),
		.mul_a      (mul_a),
		.mul_b      (mul_b),
		.mul_m      (mul_m),
		.mul_done   (mul_done),
		.mul_prod   (mul_prod)
	);

	msr_mulmod #(.W(WIDTH), .MB(MB)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.m      (mul_m),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q     <= 16'hffff;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_data;
			end
			if (fin_valid && fin_take) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fin_valid && fin_take) begin
			root_q   <= 32'(res_root);
			status_q <= res_status;
		end
	end

	assign out_valid = out_valid_q;
	assign root      = root_q;
	assign status    = status_q;

endmodule

### sv/msr_mulmod.sv
module msr_mulmod #(
	parameter int W  = 32,
	parameter int MB = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [W-1:0]  a,
	input  logic [MB-1:0] b,
	input  logic [W-1:0]  m,
	output logic          done,
	output logic [W-1:0]  prod
);

	localparam int CW = $clog2(MB + 1);

	logic [W-1:0]  a_q, m_q, r_q;
	logic [MB-1:0] b_q;
	logic [CW-1:0] cnt_q;
	logic          done_q;

	logic [W:0]   dbl, dsub, sum, ssub;
	logic [W-1:0] red, nxt;

	// one bit of b per cycle, msb first: r = 2r (+a) mod m
	always_comb begin
		dbl  = {r_q, 1'b0};
		dsub = dbl - {1'b0, m_q};
		red  = (dbl >= {1'b0, m_q}) ? dsub[W-1:0] : dbl[W-1:0];
		sum  = {1'b0, red} + {1'b0, a_q};
		ssub = sum - {1'b0, m_q};
		if (b_q[MB-1]) begin
			nxt = (sum >= {1'b0, m_q}) ? ssub[W-1:0] : sum[W-1:0];
		end else begin
			nxt = red;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CW'(MB);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			m_q <= m;
			r_q <= '0;
		end else if (cnt_q != '0) begin
			r_q <= nxt;
			b_q <= b_q << 1;
		end
	end

	assign done = done_q;
	assign prod = r_q;

endmodule

### sv/msr_seq.sv
module msr_seq #(
	parameter int W  = 32,
	parameter int MB = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [W-1:0]          v,
	input  logic [W-1:0]          p,
	input  logic [15:0]           limit,
	output logic                  idle,
	output logic                  fin_valid,
	input  logic                  fin_take,
	output logic [W-1:0]          res_root,
	output msr_pkg::status_t      res_status,
	output logic                  mul_start,
	output logic [W-1:0]          mul_a,
	output logic [MB-1:0]         mul_b,
	output logic [W-1:0]          mul_m,
	input  logic                  mul_done,
	input  logic [W-1:0]          mul_prod
);

	localparam int SW = $clog2(W + 1);
	localparam logic [W-1:0] ONE = W'(1);

	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_N     = 5'd1;
	localparam logic [4:0] S_EUL   = 5'd2;
	localparam logic [4:0] S_QS    = 5'd3;
	localparam logic [4:0] S_SHORT = 5'd4;
	localparam logic [4:0] S_ZCHK  = 5'd5;
	localparam logic [4:0] S_ZRES  = 5'd6;
	localparam logic [4:0] S_C     = 5'd7;
	localparam logic [4:0] S_T     = 5'd8;
	localparam logic [4:0] S_R     = 5'd9;
	localparam logic [4:0] S_LOOP  = 5'd10;
	localparam logic [4:0] S_SQ    = 5'd11;
	localparam logic [4:0] S_SQW   = 5'd12;
	localparam logic [4:0] S_B     = 5'd13;
	localparam logic [4:0] S_BW    = 5'd14;
	localparam logic [4:0] S_CW    = 5'd15;
	localparam logic [4:0] S_TW    = 5'd16;
	localparam logic [4:0] S_RW    = 5'd17;
	localparam logic [4:0] S_WAIT  = 5'd18;
	localparam logic [4:0] S_DONE  = 5'd19;
	localparam logic [4:0] P_START = 5'd20;
	localparam logic [4:0] P_RED   = 5'd21;
	localparam logic [4:0] P_LOOP  = 5'd22;
	localparam logic [4:0] P_MR    = 5'd23;
	localparam logic [4:0] P_SQW   = 5'd24;

	logic [4:0]    st_q, ret_q, pret_q;
	logic          mreq_q;
	logic [W-1:0]  ma_q;
	logic [MB-1:0] mb_q;
	logic [W-1:0]  p_q, n_q, q_q, c_q, t_q, r_q, tmp_q, b_q;
	logic [W-1:0]  pr_q, pb_q, pe_q;
	logic [MB-1:0] pbase_q;
	logic [SW-1:0] s_q, mm_q, i_q, j_q;
	logic [msr_pkg::ZW-1:0] z_q;
	logic [15:0]   tries_q;
	logic [W-1:0]  root_q;
	msr_pkg::status_t stat_q;
	logic [SW:0]   jsum;

	assign jsum = {1'b0, j_q} + {1'b0, i_q} + (SW+1)'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= S_IDLE;
			mreq_q <= 1'b0;
		end else begin
			mreq_q <= 1'b0;
			case (st_q)
				S_IDLE: begin
					if (start) begin
						p_q <= p;
						if (p < W'(2)) begin
							root_q <= '0;
							stat_q <= msr_pkg::ST_OK;
							st_q   <= S_DONE;
						end else if (p == W'(2)) begin
							root_q <= W'(v[0]);
							stat_q <= msr_pkg::ST_OK;
							st_q   <= S_DONE;
						end else begin
							// reduce the value: 1 * v mod p
							mreq_q <= 1'b1;
							ma_q   <= ONE;
							mb_q   <= MB'(v);
							ret_q  <= S_N;
							st_q   <= S_WAIT;
						end
					end
				end
				S_WAIT: begin
					if (mul_done) begin
						st_q <= ret_q;
					end
				end
				S_N: begin
					n_q <= mul_prod;
					if (mul_prod == '0) begin
						root_q <= '0;
						stat_q <= msr_pkg::ST_OK;
						st_q   <= S_DONE;
					end else begin
						pbase_q <= MB'(mul_prod);
						pe_q    <= p_q >> 1;
						pret_q  <= S_EUL;
						st_q    <= P_START;
					end
				end
				S_EUL: begin
					if (pr_q != ONE) begin
						root_q <= '0;
						stat_q <= msr_pkg::ST_NONRES;
						st_q   <= S_DONE;
					end else begin
						q_q  <= p_q - ONE;
						s_q  <= '0;
						st_q <= S_QS;
					end
				end
				S_QS: begin
					if (q_q != '0 && !q_q[0]) begin
						q_q <= q_q >> 1;
						s_q <= s_q + 1'b1;
					end else if (s_q == SW'(1)) begin
						pbase_q <= MB'(n_q);
						pe_q    <= (p_q >> 2) + ONE;
						pret_q  <= S_SHORT;
						st_q    <= P_START;
					end else begin
						z_q     <= msr_pkg::ZW'(2);
						tries_q <= '0;
						st_q    <= S_ZCHK;
					end
				end
				S_SHORT: begin
					root_q <= pr_q;
					stat_q <= msr_pkg::ST_OK;
					st_q   <= S_DONE;
				end
				S_ZCHK: begin
					if (tries_q < limit) begin
						pbase_q <= MB'(z_q);
						pe_q    <= p_q >> 1;
						pret_q  <= S_ZRES;
						st_q    <= P_START;
					end else begin
						root_q <= '0;
						stat_q <= msr_pkg::ST_LIMIT;
						st_q   <= S_DONE;
					end
				end
				S_ZRES: begin
					if (pr_q == p_q - ONE) begin
						mm_q    <= s_q;
						pbase_q <= MB'(z_q);
						pe_q    <= q_q;
						pret_q  <= S_C;
						st_q    <= P_START;
					end else begin
						tries_q <= tries_q + 1'b1;
						z_q     <= z_q + 1'b1;
						st_q    <= S_ZCHK;
					end
				end
				S_C: begin
					c_q     <= pr_q;
					pbase_q <= MB'(n_q);
					pe_q    <= q_q;
					pret_q  <= S_T;
					st_q    <= P_START;
				end
				S_T: begin
					t_q     <= pr_q;
					pbase_q <= MB'(n_q);
					pe_q    <= (q_q >> 1) + ONE;
					pret_q  <= S_R;
					st_q    <= P_START;
				end
				S_R: begin
					r_q  <= pr_q;
					st_q <= S_LOOP;
				end
				S_LOOP: begin
					if (t_q == ONE) begin
						root_q <= r_q;
						stat_q <= msr_pkg::ST_OK;
						st_q   <= S_DONE;
					end else begin
						i_q   <= '0;
						tmp_q <= t_q;
						st_q  <= S_SQ;
					end
				end
				S_SQ: begin
					if (tmp_q != ONE && i_q < mm_q) begin
						mreq_q <= 1'b1;
						ma_q   <= tmp_q;
						mb_q   <= MB'(tmp_q);
						ret_q  <= S_SQW;
						st_q   <= S_WAIT;
					end else if (tmp_q != ONE || i_q >= mm_q) begin
						root_q <= '0;
						stat_q <= msr_pkg::ST_NONRES;
						st_q   <= S_DONE;
					end else begin
						b_q  <= c_q;
						j_q  <= '0;
						st_q <= S_B;
					end
				end
				S_SQW: begin
					tmp_q <= mul_prod;
					i_q   <= i_q + 1'b1;
					st_q  <= S_SQ;
				end
				S_B: begin
					mreq_q <= 1'b1;
					ma_q   <= b_q;
					mb_q   <= MB'(b_q);
					st_q   <= S_WAIT;
					if (jsum < {1'b0, mm_q}) begin
						ret_q <= S_BW;
					end else begin
						mm_q  <= i_q;
						ret_q <= S_CW;
					end
				end
				S_BW: begin
					b_q  <= mul_prod;
					j_q  <= j_q + 1'b1;
					st_q <= S_B;
				end
				S_CW: begin
					c_q    <= mul_prod;
					mreq_q <= 1'b1;
					ma_q   <= t_q;
					mb_q   <= MB'(mul_prod);
					ret_q  <= S_TW;
					st_q   <= S_WAIT;
				end
				S_TW: begin
					t_q    <= mul_prod;
					mreq_q <= 1'b1;
					ma_q   <= r_q;
					mb_q   <= MB'(b_q);
					ret_q  <= S_RW;
					st_q   <= S_WAIT;
				end
				S_RW: begin
					r_q  <= mul_prod;
					st_q <= S_LOOP;
				end
				// modular power: reduce the base, then square-and-multiply lsb first
				P_START: begin
					pr_q   <= ONE;
					mreq_q <= 1'b1;
					ma_q   <= ONE;
					mb_q   <= pbase_q;
					ret_q  <= P_RED;
					st_q   <= S_WAIT;
				end
				P_RED: begin
					pb_q <= mul_prod;
					st_q <= P_LOOP;
				end
				P_LOOP: begin
					if (pe_q == '0) begin
						st_q <= pret_q;
					end else begin
						mreq_q <= 1'b1;
						st_q   <= S_WAIT;
						if (pe_q[0]) begin
							ma_q  <= pr_q;
							mb_q  <= MB'(pb_q);
							ret_q <= P_MR;
						end else begin
							ma_q  <= pb_q;
							mb_q  <= MB'(pb_q);
							ret_q <= P_SQW;
						end
					end
				end
				P_MR: begin
					pr_q   <= mul_prod;
					mreq_q <= 1'b1;
					ma_q   <= pb_q;
					mb_q   <= MB'(pb_q);
					ret_q  <= P_SQW;
					st_q   <= S_WAIT;
				end
				P_SQW: begin
					pb_q <= mul_prod;
					pe_q <= pe_q >> 1;
					st_q <= P_LOOP;
				end
				S_DONE: begin
					if (fin_take) begin
						st_q <= S_IDLE;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	assign idle       = (st_q == S_IDLE);
	assign fin_valid  = (st_q == S_DONE);
	assign res_root   = root_q;
	assign res_status = stat_q;
	assign mul_start  = mreq_q;
	assign mul_a      = ma_q;
	assign mul_b      = mb_q;
	assign mul_m      = p_q;

endmodule

### sv/msr_check.sv
`include "assert_macros.svh"

module msr_check (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] root,
	input logic [1:0]  status
);

	// a waiting word holds still
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(root) && $stable(status))

	// status never carries the unused code
	`ASSERT_SAME(a_status_code, clk, arst_n, out_valid, status != 2'd3)

	// a failed search or check gives no root
	`ASSERT_SAME(a_root_zero, clk, arst_n, out_valid && status != msr_pkg::ST_OK, root == 32'd0)

	// one item at a time: busy right after a word is taken in
	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)

endmodule

bind modular_square_root_top msr_check u_msr_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.root      (root),
	.status    (status)
);
